// File: sv/bilinear_sample_with_gradient_core_assert.svh
// Assertion macros shared by the bilinear sampler RTL.
`ifndef BILINEAR_SAMPLE_WITH_GRADIENT_CORE_ASSERT_SVH
`define BILINEAR_SAMPLE_WITH_GRADIENT_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BSG_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("bsg: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define BSG_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("bsg: next-cycle check failed");

`endif

// File: sv/bsg_pkg.sv
// Shared constants and types of the bilinear sampler.
`default_nettype none
package bsg_pkg;
    localparam int CFG_W   = 10;
    localparam int POS_W   = 9;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 17;
    localparam int VALUE_W = 24;
    localparam int GRAD_W  = 25;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic CFG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] DIM_RESET = 10'd512;

    typedef logic [PIX_W-1:0] t_pixel;
endpackage
`default_nettype wire

// File: sv/bsg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_waddr] <= i_wdata;
            end
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: sv/bilinear_sample_with_gradient_core.sv
// Throughput: one request per cycle while the output is not stalled.
// Writes give no result and leave no gap.
// A stalled result freezes the whole pipeline, including the memory read data.
// Reset clears all valid bits and sets both image dimensions to 512.
// The image memory is not cleared; pixels must be written before being read.
`default_nettype none
`include "bilinear_sample_with_gradient_core_assert.svh"
module bilinear_sample_with_gradient_core #(
    parameter int MAX_WIDTH       = 512,
    parameter int MAX_HEIGHT      = 512,
    parameter int COORD_FRAC_BITS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [bsg_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_opcode,
    input  wire logic [bsg_pkg::POS_W-1:0]     i_pixel_col,
    input  wire logic [bsg_pkg::POS_W-1:0]     i_pixel_row,
    input  wire logic [bsg_pkg::PIX_W-1:0]     i_pixel_value,
    input  wire logic [bsg_pkg::COORD_W-1:0]   i_sample_x,
    input  wire logic [bsg_pkg::COORD_W-1:0]   i_sample_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bsg_pkg::VALUE_W-1:0]        o_value,
    output logic signed [bsg_pkg::GRAD_W-1:0]  o_grad_x,
    output logic signed [bsg_pkg::GRAD_W-1:0]  o_grad_y,
    output logic                               o_out_of_range
);
    import bsg_pkg::*;

    localparam int F        = COORD_FRAC_BITS;
    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW       = $clog2(DEPTH);
    localparam int BDEPTH   = (DEPTH + 3) / 4;
    localparam int BAW      = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int IW       = COORD_W - F;
    localparam int XW       = ((IW > CFG_W) ? IW : CFG_W) + 1;
    localparam int CW       = ((AW > 2 * CFG_W) ? AW : 2 * CFG_W) + 2;
    localparam int WGT_W    = 2 * F + 1;
    localparam int WP_W     = 2 * F + 2;
    localparam int VPW      = WGT_W + PIX_W;
    localparam int DPW      = WGT_W + PIX_W + 2;
    localparam int VSW      = VPW + 2;
    localparam int DSW      = DPW + 2;

    typedef struct packed {
        logic                   op;
        logic                   ok;
        logic [3:0][WGT_W-1:0]  wgt;
    } t_side;

    logic w_en;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [CFG_W-1:0] w_eff_w;
    logic [CFG_W-1:0] w_eff_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= DIM_RESET;
            r_cfg_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_eff_w = (32'(r_cfg_width) < MAX_WIDTH) ? r_cfg_width : CFG_W'(MAX_WIDTH);
    assign w_eff_h = (32'(r_cfg_height) < MAX_HEIGHT) ? r_cfg_height : CFG_W'(MAX_HEIGHT);

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Stage 0: registered request.
    logic               r0_valid;
    logic               r0_op;
    logic [POS_W-1:0]   r0_col;
    logic [POS_W-1:0]   r0_row;
    t_pixel             r0_pval;
    logic [COORD_W-1:0] r0_sx;
    logic [COORD_W-1:0] r0_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (w_en) begin
            r0_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_op   <= i_opcode;
            r0_col  <= i_pixel_col;
            r0_row  <= i_pixel_row;
            r0_pval <= i_pixel_value;
            r0_sx   <= i_sample_x;
            r0_sy   <= i_sample_y;
        end
    end

    // Stage 0 logic: range checks, blend weights, row and column selection.
    logic [XW-1:0]    w_ix;
    logic [XW-1:0]    w_iy;
    logic [F:0]       w_gx;
    logic [F:0]       w_gy;
    logic [F:0]       w_fx;
    logic [F:0]       w_fy;
    logic [WP_W-1:0]  w_p00;
    logic [WP_W-1:0]  w_p01;
    logic [WP_W-1:0]  w_p10;
    logic [WP_W-1:0]  w_p11;
    logic             w_inside;
    logic             w_wr_ok;
    logic [CFG_W-1:0] w_rowsel;
    logic [CFG_W-1:0] w_colsel;

    assign w_ix = XW'(r0_sx[COORD_W-1:F]);
    assign w_iy = XW'(r0_sy[COORD_W-1:F]);
    assign w_fx = {1'b0, r0_sx[F-1:0]};
    assign w_fy = {1'b0, r0_sy[F-1:0]};
    assign w_gx = {1'b1, {F{1'b0}}} - w_fx;
    assign w_gy = {1'b1, {F{1'b0}}} - w_fy;

    assign w_p00 = WP_W'(w_gx) * WP_W'(w_gy);
    assign w_p01 = WP_W'(w_gx) * WP_W'(w_fy);
    assign w_p10 = WP_W'(w_fx) * WP_W'(w_gy);
    assign w_p11 = WP_W'(w_fx) * WP_W'(w_fy);

    assign w_inside = (w_ix != '0) && (w_ix + XW'(3) <= XW'(w_eff_w))
                   && (w_iy != '0) && (w_iy + XW'(3) <= XW'(w_eff_h));
    assign w_wr_ok  = (CFG_W'(r0_col) < w_eff_w) && (CFG_W'(r0_row) < w_eff_h);

    assign w_rowsel = (r0_op == OP_SAMPLE) ? CFG_W'(w_iy - XW'(1)) : CFG_W'(r0_row);
    assign w_colsel = (r0_op == OP_SAMPLE) ? CFG_W'(w_ix - XW'(1)) : CFG_W'(r0_col);

    // Stage 1.
    logic             r1_valid;
    t_side            r1_side;
    t_pixel           r1_pval;
    logic [CFG_W-1:0] r1_rowsel;
    logic [CFG_W-1:0] r1_colsel;
    logic [CFG_W-1:0] r1_w;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_side.op     <= r0_op;
            r1_side.ok     <= (r0_op == OP_SAMPLE) ? w_inside : w_wr_ok;
            r1_side.wgt[0] <= w_p00[WGT_W-1:0];
            r1_side.wgt[1] <= w_p01[WGT_W-1:0];
            r1_side.wgt[2] <= w_p10[WGT_W-1:0];
            r1_side.wgt[3] <= w_p11[WGT_W-1:0];
            r1_pval        <= r0_pval;
            r1_rowsel      <= w_rowsel;
            r1_colsel      <= w_colsel;
            r1_w           <= w_eff_w;
        end
    end

    // Stage 2: row times stride.
    logic          r2_valid;
    t_side         r2_side;
    t_pixel        r2_pval;
    logic [CW-1:0] r2_prod;
    logic [CW-1:0] r2_col;
    logic [CW-1:0] r2_w1;
    logic [CW-1:0] r2_w2;
    logic [CW-1:0] r2_w3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_side <= r1_side;
            r2_pval <= r1_pval;
            r2_prod <= CW'(r1_rowsel) * CW'(r1_w);
            r2_col  <= CW'(r1_colsel);
            r2_w1   <= CW'(r1_w);
            r2_w2   <= CW'(r1_w) << 1;
            r2_w3   <= CW'(r1_w) + (CW'(r1_w) << 1);
        end
    end

    // Stage 3: start addresses of the four window rows.
    logic          w_base;
    logic [CW-1:0] w_base_addr;

    assign w_base_addr = r2_prod + r2_col;
    assign w_base      = r2_valid && (r2_side.op == OP_WRITE) && r2_side.ok;

    logic                 r3_valid;
    logic                 r3_we;
    t_side                r3_side;
    t_pixel               r3_pval;
    logic [AW-1:0]        r3_base;
    logic [3:0][AW-1:0]   r3_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r3_we    <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
            r3_we    <= w_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_side    <= r2_side;
            r3_pval    <= r2_pval;
            r3_base    <= AW'(w_base_addr);
            r3_addr[0] <= AW'(w_base_addr + CW'(1));
            r3_addr[1] <= AW'(w_base_addr + r2_w1);
            r3_addr[2] <= AW'(w_base_addr + r2_w2);
            r3_addr[3] <= AW'(w_base_addr + r2_w3 + CW'(1));
        end
    end

    // Memory: four copies of the image, each split into four banks by address.
    t_pixel [3:0][3:0] w_rd;

    for (genvar k = 0; k < 4; k++) begin : g_copy
        for (genvar b = 0; b < 4; b++) begin : g_bank
            logic [1:0]  w_j;
            logic [AW:0] w_sum;

            assign w_j   = 2'(b) - r3_addr[k][1:0];
            assign w_sum = {1'b0, r3_addr[k]} + (AW + 1)'(w_j);

            bsg_ram #(
                .WIDTH (PIX_W),
                .DEPTH (BDEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_en    (w_en),
                .i_we    (r3_we && (r3_base[1:0] == 2'(b))),
                .i_waddr (BAW'(r3_base >> 2)),
                .i_wdata (r3_pval),
                .i_raddr (BAW'(w_sum >> 2)),
                .o_rdata (w_rd[k][b])
            );
        end
    end

    // Stage 4: read data arrives; align pixels and form products.
    logic               r4_valid;
    t_side              r4_side;
    logic [3:0][1:0]    r4_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_side     <= r3_side;
            r4_lo[0]    <= r3_addr[0][1:0];
            r4_lo[1]    <= r3_addr[1][1:0];
            r4_lo[2]    <= r3_addr[2][1:0];
            r4_lo[3]    <= r3_addr[3][1:0];
        end
    end

    t_pixel [1:0][3:0] w_mid;
    t_pixel [1:0][1:0] w_edge;

    for (genvar c = 0; c < 4; c++) begin : g_mid
        assign w_mid[0][c] = w_rd[1][2'(r4_lo[1] + 2'(c))];
        assign w_mid[1][c] = w_rd[2][2'(r4_lo[2] + 2'(c))];
    end
    for (genvar c = 0; c < 2; c++) begin : g_edge
        assign w_edge[0][c] = w_rd[0][2'(r4_lo[0] + 2'(c))];
        assign w_edge[1][c] = w_rd[3][2'(r4_lo[3] + 2'(c))];
    end

    logic signed [3:0][PIX_W:0] w_dx;
    logic signed [3:0][PIX_W:0] w_dy;

    assign w_dx[0] = $signed({1'b0, w_mid[0][2]}) - $signed({1'b0, w_mid[0][0]});
    assign w_dx[1] = $signed({1'b0, w_mid[1][2]}) - $signed({1'b0, w_mid[1][0]});
    assign w_dx[2] = $signed({1'b0, w_mid[0][3]}) - $signed({1'b0, w_mid[0][1]});
    assign w_dx[3] = $signed({1'b0, w_mid[1][3]}) - $signed({1'b0, w_mid[1][1]});
    assign w_dy[0] = $signed({1'b0, w_mid[1][1]}) - $signed({1'b0, w_edge[0][0]});
    assign w_dy[1] = $signed({1'b0, w_edge[1][0]}) - $signed({1'b0, w_mid[0][1]});
    assign w_dy[2] = $signed({1'b0, w_mid[1][2]}) - $signed({1'b0, w_edge[0][1]});
    assign w_dy[3] = $signed({1'b0, w_edge[1][1]}) - $signed({1'b0, w_mid[0][2]});

    t_pixel [3:0] w_vp;
    assign w_vp[0] = w_mid[0][1];
    assign w_vp[1] = w_mid[1][1];
    assign w_vp[2] = w_mid[0][2];
    assign w_vp[3] = w_mid[1][2];

    logic                      r5_valid;
    logic                      r5_op;
    logic                      r5_ok;
    logic [3:0][VPW-1:0]       r5_vprod;
    logic signed [DPW-1:0]     r5_xprod [4];
    logic signed [DPW-1:0]     r5_yprod [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (w_en) begin
            r5_valid <= r4_valid;
        end
    end

    for (genvar t = 0; t < 4; t++) begin : g_prod
        logic signed [DPW-1:0] w_wgt_s;

        assign w_wgt_s = $signed(DPW'(r4_side.wgt[t]));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r5_vprod[t] <= VPW'(r4_side.wgt[t]) * VPW'(w_vp[t]);
                r5_xprod[t] <= w_wgt_s * DPW'($signed(w_dx[t]));
                r5_yprod[t] <= w_wgt_s * DPW'($signed(w_dy[t]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_op <= r4_side.op;
            r5_ok <= r4_side.ok;
        end
    end

    // Stage 6: sums into the output register.
    logic [VSW-1:0]        w_vsum;
    logic signed [DSW-1:0] w_xsum;
    logic signed [DSW-1:0] w_ysum;

    assign w_vsum = VSW'(r5_vprod[0]) + VSW'(r5_vprod[1])
                  + VSW'(r5_vprod[2]) + VSW'(r5_vprod[3]);
    assign w_xsum = DSW'(r5_xprod[0]) + DSW'(r5_xprod[1])
                  + DSW'(r5_xprod[2]) + DSW'(r5_xprod[3]);
    assign w_ysum = DSW'(r5_yprod[0]) + DSW'(r5_yprod[1])
                  + DSW'(r5_yprod[2]) + DSW'(r5_yprod[3]);

    logic                     r_out_valid;
    logic [VALUE_W-1:0]       r_value;
    logic signed [GRAD_W-1:0] r_grad_x;
    logic signed [GRAD_W-1:0] r_grad_y;
    logic                     r_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r5_valid && (r5_op == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_value  <= r5_ok ? VALUE_W'(w_vsum) : '0;
            r_grad_x <= r5_ok ? GRAD_W'(w_xsum) : '0;
            r_grad_y <= r5_ok ? GRAD_W'(w_ysum) : '0;
            r_oor    <= !r5_ok;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_value        = r_value;
    assign o_grad_x       = r_grad_x;
    assign o_grad_y       = r_grad_y;
    assign o_out_of_range = r_oor;

    logic w_out_zero;
    assign w_out_zero = (o_value == '0) && (o_grad_x == '0) && (o_grad_y == '0);

    `BSG_ASSERT_IMP(a_oor_zero, o_out_valid && o_out_of_range, w_out_zero)
    `BSG_ASSERT_NEXT(a_write_silent, w_en && r5_valid && (r5_op == OP_WRITE), !o_out_valid)
    `BSG_ASSERT_IMP(a_write_in_store, r3_we, 32'(r3_base) < DEPTH)
    `BSG_ASSERT_NEXT(a_stall_holds, !w_en && r5_valid, r5_valid)
endmodule
`default_nettype wire
